// ===== hdl/lpm_pkg.sv =====
// Shared types, codes and helpers for the IPv4 longest-prefix-match engine.
package lpm_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 6;
  localparam int TTL_W     = 8;
  localparam int CSUM_W    = 16;
  localparam int ACC_W     = 20;   // ten 16-bit halves sum below 2^20
  localparam int HIDX_W    = 4;    // halfword counter
  localparam logic [LEN_W-1:0]  MAX_LEN   = 6'd32;
  localparam logic [HIDX_W-1:0] LAST_HALF = 4'd9;

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_FORWARD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    V_LOCAL   = 3'd0,
    V_FORWARD = 3'd1,
    V_TTL     = 3'd2,
    V_NOROUTE = 3'd3,
    V_STORED  = 3'd4,
    V_FULL    = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_HOP,
    ST_CSUM,
    ST_FOLD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] route_prefix;
    logic [LEN_W-1:0]  route_mask_len;
    logic [ADDR_W-1:0] route_next_hop;
    logic [31:0]       header_word0;
    logic [31:0]       header_word1;
    logic [31:0]       header_word2;
    logic [31:0]       header_word3;
    logic [31:0]       header_word4;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        verdict;
    logic [ADDR_W-1:0] next_hop;
    logic [TTL_W-1:0]  new_ttl;
    logic [CSUM_W-1:0] new_checksum;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] prefix;
  } route_key_t;

  // Network mask for a prefix length of 0..32; length zero gives an all-zero mask
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~(32'hffff_ffff >> len);
  endfunction

endpackage

// ===== hdl/lpm_ifs.sv =====
// Valid/ready channel interfaces for the engine's input and result items.
interface lpm_in_if import lpm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface lpm_out_if import lpm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/ipv4_lpm_forwarding_engine.sv =====
// IPv4 forwarding engine: route table with sequential longest-prefix scan and TTL/checksum update.
// Local delivery goes straight to the result; add, no route and TTL discard scan the
// stored routes and decide; a forwarded header also reads its next hop, then sums and
// folds the checksum. The scan reads one entry per cycle from a memory with one write
// port and a registered read port; the checksum adds one 16-bit half per cycle on one adder.
// One item at a time; the next is taken the cycle after its result is registered.
// Synchronous active-low reset empties the table (fill count 0) and clears local_addr.
module ipv4_lpm_forwarding_engine import lpm_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  lpm_in_if.sink            in_ch,
  lpm_out_if.source         out_ch
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // Control state
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] local_addr_r;
  logic [CNT_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers
  in_item_t          item_r, item_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [HIDX_W-1:0] half_idx_r, half_idx_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  verdict_t          res_verdict_r, res_verdict_nxt;
  logic [ADDR_W-1:0] res_hop_r, res_hop_nxt;
  logic [TTL_W-1:0]  res_ttl_r, res_ttl_nxt;
  logic [CSUM_W-1:0] res_csum_r, res_csum_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // Route table memory
  route_key_t        key_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] hop_mem [TABLE_ENTRIES];
  route_key_t        key_q;
  logic [ADDR_W-1:0] hop_q;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              mem_we;

  // Derived values
  logic              in_accept;
  logic              is_local;
  logic              scan_issue;
  logic              scan_done;
  logic [LEN_W-1:0]  add_len;
  logic [ADDR_W-1:0] add_pfx;
  logic [TTL_W-1:0]  dec_ttl;
  logic              add_hit;
  logic              fwd_hit;
  logic              take_hit;
  logic [CSUM_W-1:0] half;
  logic [CSUM_W:0]   fold1;
  logic [CSUM_W-1:0] fold2;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign is_local     = (in_ch.item.operation == OP_FORWARD) &&
                        (in_ch.item.header_word4 == local_addr_r);
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  // Add operand: saturate the length, mask the prefix
  assign add_len = (item_r.route_mask_len > MAX_LEN) ? MAX_LEN : item_r.route_mask_len;
  assign add_pfx = item_r.route_prefix & len_mask(add_len);
  assign dec_ttl = item_r.header_word2[31:24] - 8'd1;

  // Scan control: one read issued per cycle, compared in the cycle after
  assign scan_issue = (state_r == ST_SCAN) && (scan_idx_r < fill_cnt_r);
  assign scan_done  = (state_r == ST_SCAN) && !scan_issue && !cmp_vld_r;
  assign rd_addr    = (state_r == ST_SCAN) ? scan_idx_r[IDX_W-1:0] : best_idx_r;

  // Entry compare: exact key for add, longest match for forward
  assign add_hit  = (key_q.len == add_len) && (key_q.prefix == add_pfx);
  assign fwd_hit  = ((item_r.header_word4 & len_mask(key_q.len)) == key_q.prefix);
  assign take_hit = (item_r.operation == OP_FORWARD) ?
                    (fwd_hit && (!found_r || (key_q.len > best_len_r))) :
                    (add_hit && !found_r);

  // Checksum halfword select; word2 carries the new TTL and a zero checksum
  always_comb begin
    case (half_idx_r)
      4'd0:    half = item_r.header_word0[31:16];
      4'd1:    half = item_r.header_word0[15:0];
      4'd2:    half = item_r.header_word1[31:16];
      4'd3:    half = item_r.header_word1[15:0];
      4'd4:    half = {dec_ttl, item_r.header_word2[23:16]};
      4'd5:    half = '0;
      4'd6:    half = item_r.header_word3[31:16];
      4'd7:    half = item_r.header_word3[15:0];
      4'd8:    half = item_r.header_word4[31:16];
      4'd9:    half = item_r.header_word4[15:0];
      default: half = '0;
    endcase
  end

  // End-around carry fold of the 20-bit sum
  assign fold1 = {1'b0, acc_r[CSUM_W-1:0]} + {13'd0, acc_r[ACC_W-1:CSUM_W]};
  assign fold2 = fold1[CSUM_W-1:0] + {15'd0, fold1[CSUM_W]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = is_local ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (item_r.operation == OP_FORWARD && found_r && dec_ttl != '0) begin
          state_nxt = ST_HOP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_HOP:  state_nxt = ST_CSUM;
      ST_CSUM: begin
        if (half_idx_r == LAST_HALF) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and table updates per state
  always_comb begin
    item_nxt        = item_r;
    fill_cnt_nxt    = fill_cnt_r;
    scan_idx_nxt    = scan_idx_r;
    cmp_vld_nxt     = scan_issue;
    cmp_idx_nxt     = scan_idx_r[IDX_W-1:0];
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_len_nxt    = best_len_r;
    half_idx_nxt    = half_idx_r;
    acc_nxt         = acc_r;
    res_verdict_nxt = res_verdict_r;
    res_hop_nxt     = res_hop_r;
    res_ttl_nxt     = res_ttl_r;
    res_csum_nxt    = res_csum_r;
    out_item_nxt    = out_item_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    mem_we          = 1'b0;
    wr_addr         = best_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt        = in_ch.item;
          scan_idx_nxt    = '0;
          found_nxt       = 1'b0;
          best_len_nxt    = '0;
          res_verdict_nxt = V_LOCAL;
          res_hop_nxt     = '0;
          res_ttl_nxt     = '0;
          res_csum_nxt    = '0;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (cmp_vld_r && take_hit) begin
          found_nxt    = 1'b1;
          best_idx_nxt = cmp_idx_r;
          best_len_nxt = key_q.len;
        end
      end
      ST_DECIDE: begin
        if (item_r.operation == OP_ADD) begin
          if (found_r) begin
            mem_we          = 1'b1;
            res_verdict_nxt = V_STORED;
          end else if (fill_cnt_r < FULL_CNT) begin
            mem_we          = 1'b1;
            wr_addr         = fill_cnt_r[IDX_W-1:0];
            fill_cnt_nxt    = fill_cnt_r + CNT_W'(1);
            res_verdict_nxt = V_STORED;
          end else begin
            res_verdict_nxt = V_FULL;
          end
        end else if (!found_r) begin
          res_verdict_nxt = V_NOROUTE;
        end else if (dec_ttl == '0) begin
          res_verdict_nxt = V_TTL;
        end
      end
      ST_HOP: begin
        res_hop_nxt  = hop_q;
        half_idx_nxt = '0;
        acc_nxt      = '0;
      end
      ST_CSUM: begin
        acc_nxt      = acc_r + {4'd0, half};
        half_idx_nxt = half_idx_r + 4'd1;
      end
      ST_FOLD: begin
        res_verdict_nxt = V_FORWARD;
        res_ttl_nxt     = dec_ttl;
        res_csum_nxt    = ~fold2;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_item_nxt.verdict      = res_verdict_r;
          out_item_nxt.next_hop     = res_hop_r;
          out_item_nxt.new_ttl      = res_ttl_r;
          out_item_nxt.new_checksum = res_csum_r;
          out_valid_nxt             = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      local_addr_r <= '0;
      fill_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      if (cfg_we) begin
        local_addr_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    scan_idx_r    <= scan_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    found_r       <= found_nxt;
    best_idx_r    <= best_idx_nxt;
    best_len_r    <= best_len_nxt;
    half_idx_r    <= half_idx_nxt;
    acc_r         <= acc_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_hop_r     <= res_hop_nxt;
    res_ttl_r     <= res_ttl_nxt;
    res_csum_r    <= res_csum_nxt;
    out_item_r    <= out_item_nxt;
  end

  // Route table: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= '{len: add_len, prefix: add_pfx};
      hop_mem[wr_addr] <= item_r.route_next_hop;
    end
    key_q <= key_mem[rd_addr];
    hop_q <= hop_mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= FULL_CNT)
    else $error("route fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && fill_cnt_r != $past(fill_cnt_r)) |->
      ($past(state_r) == ST_DECIDE && fill_cnt_r == $past(fill_cnt_r) + CNT_W'(1)))
    else $error("fill count changed outside a route insert");

  a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.verdict == V_FORWARD) |-> (out_item_r.new_ttl != '0))
    else $error("forwarded item with zero TTL");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.verdict != V_FORWARD) |->
      (out_item_r.next_hop == '0 && out_item_r.new_checksum == '0))
    else $error("non-forward result carries hop or checksum");
`endif

endmodule

// ===== bench/tb_ipv4_lpm_forwarding_engine.sv =====
// Testbench for the IPv4 LPM forwarding engine: route adds and headers checked by a predictor.
module tb_ipv4_lpm_forwarding_engine;
  import lpm_pkg::*;

  localparam int ROUTE_SLOTS   = 64;
  localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
  localparam int PHASE_ITEMS   = 467;
  localparam int OPEN_SLOT_CAP = 56;    // keep room for the default route until the last phase
  localparam int SETTLE_CYCLES = 100;   // room for the longest forward at 64 routes

  // Route table model, expected results and mismatch count
  class lpm_scoreboard;
    logic [ADDR_W-1:0] local_addr;
    bit                ent_valid [ROUTE_SLOTS];
    logic [LEN_W-1:0]  ent_len   [ROUTE_SLOTS];
    logic [ADDR_W-1:0] ent_prefix[ROUTE_SLOTS];
    logic [ADDR_W-1:0] ent_hop   [ROUTE_SLOTS];
    out_item_t         expected_verdicts[$];
    int                errors;

    function new();
      local_addr = '0;
      errors     = 0;
      for (int i = 0; i < ROUTE_SLOTS; i++) begin
        ent_valid[i]  = 1'b0;
        ent_len[i]    = '0;
        ent_prefix[i] = '0;
        ent_hop[i]    = '0;
      end
    endfunction

    function logic [ADDR_W-1:0] prefix_mask(logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      return 32'hffff_ffff << (32 - int'(len));
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (ent_valid[i]) if (ent_valid[i]) n++;
      return n;
    endfunction

    // Random stored route; caller makes sure the table is not empty
    function void pick_route(output logic [ADDR_W-1:0] pfx, output logic [LEN_W-1:0] len);
      int slots[$];
      foreach (ent_valid[i]) if (ent_valid[i]) slots.push_back(i);
      pfx = ent_prefix[slots[$urandom_range(slots.size() - 1)]];
      len = '0;
      foreach (ent_valid[i]) if (ent_valid[i] && ent_prefix[i] == pfx) len = ent_len[i];
    endfunction

    // Apply one item to the table model and return what the engine should answer
    function out_item_t route_decision(in_item_t it);
      out_item_t         r;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] pfx;
      logic [31:0]       w[5];
      logic [TTL_W-1:0]  ttl;
      logic [31:0]       sum;
      int                slot, free_slot, best;
      r = '0;
      if (it.operation == OP_ADD) begin
        len = (it.route_mask_len > MAX_LEN) ? MAX_LEN : it.route_mask_len;
        pfx = it.route_prefix & prefix_mask(len);
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (ent_valid[i]) begin
            if (ent_len[i] == len && ent_prefix[i] == pfx && slot < 0) slot = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (slot < 0) slot = free_slot;
        if (slot < 0) begin
          r.verdict = V_FULL;
        end else begin
          ent_valid[slot]  = 1'b1;
          ent_len[slot]    = len;
          ent_prefix[slot] = pfx;
          ent_hop[slot]    = it.route_next_hop;
          r.verdict = V_STORED;
        end
      end else begin
        w = '{it.header_word0, it.header_word1, it.header_word2, it.header_word3,
              it.header_word4};
        if (w[4] == local_addr) begin
          r.verdict = V_LOCAL;
        end else begin
          // longest match wins, lowest slot on a tie
          best = -1;
          for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (ent_valid[i] && (w[4] & prefix_mask(ent_len[i])) == ent_prefix[i] &&
                (best < 0 || ent_len[i] > ent_len[best]))
              best = i;
          end
          if (best < 0) begin
            r.verdict = V_NOROUTE;
          end else begin
            ttl = w[2][31:24] - 8'd1;
            if (ttl == 0) begin
              r.verdict = V_TTL;
            end else begin
              // checksum over the header with new TTL and a zeroed checksum field
              w[2] = {ttl, w[2][23:16], 16'h0000};
              sum = '0;
              for (int i = 0; i < 5; i++) sum = sum + w[i][31:16] + w[i][15:0];
              while (sum[31:16] != 0) sum = sum[31:16] + sum[15:0];
              r.verdict      = V_FORWARD;
              r.next_hop     = ent_hop[best];
              r.new_ttl      = ttl;
              r.new_checksum = ~sum[15:0];
            end
          end
        end
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      expected_verdicts.push_back(route_decision(it));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result, verdict %0d", got.verdict));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.verdict !== want.verdict)
        report_mismatch($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
      if (got.next_hop !== want.next_hop)
        report_mismatch($sformatf("next_hop %h, want %h", got.next_hop, want.next_hop));
      if (got.new_ttl !== want.new_ttl)
        report_mismatch($sformatf("new_ttl %0d, want %0d", got.new_ttl, want.new_ttl));
      if (got.new_checksum !== want.new_checksum)
        report_mismatch($sformatf("new_checksum %h, want %h", got.new_checksum,
                                  want.new_checksum));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                stall_cycles = 0;
  lpm_scoreboard     sb;

  lpm_in_if  in_ch ();
  lpm_out_if out_ch ();

  ipv4_lpm_forwarding_engine #(
    .TABLE_ENTRIES (ROUTE_SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  // Result side: check accepted items, random backpressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.item);
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function in_item_t route_add_item(logic [31:0] pfx, logic [LEN_W-1:0] len,
                                    logic [31:0] hop);
    in_item_t it;
    it.operation      = OP_ADD;
    it.route_prefix   = pfx;
    it.route_mask_len = len;
    it.route_next_hop = hop;
    it.header_word0   = $urandom;
    it.header_word1   = $urandom;
    it.header_word2   = $urandom;
    it.header_word3   = $urandom;
    it.header_word4   = $urandom;
    return it;
  endfunction

  // Header with the given destination and TTL; other header words filled with fill, route fields with ~fill
  function in_item_t header_item(logic [31:0] dest, logic [TTL_W-1:0] ttl, logic [31:0] fill);
    in_item_t it;
    it.operation      = OP_FORWARD;
    it.route_prefix   = ~fill;
    it.route_mask_len = ~fill[5:0];
    it.route_next_hop = ~fill;
    it.header_word0   = fill;
    it.header_word1   = fill;
    it.header_word2   = {ttl, fill[23:0]};
    it.header_word3   = fill;
    it.header_word4   = dest;
    return it;
  endfunction

  // Mixed traffic: some adds overwrite stored routes, some headers hit stored routes
  function in_item_t random_item(bit may_fill);
    in_item_t          it;
    logic [ADDR_W-1:0] pfx;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  ttl;
    int                roll;
    if ($urandom_range(99) < 40) begin
      if (sb.occupancy() > 0 && ($urandom_range(99) < 30 ||
          (!may_fill && sb.occupancy() >= OPEN_SLOT_CAP))) begin
        sb.pick_route(pfx, len);
        pfx = pfx | ($urandom & ~sb.prefix_mask(len));
        if (len == MAX_LEN && $urandom_range(1) == 1) len = LEN_W'($urandom_range(33, 63));
      end else begin
        pfx  = $urandom;
        roll = $urandom_range(99);
        if (roll < 15) len = LEN_W'($urandom_range(33, 63));
        else if (may_fill) len = LEN_W'($urandom_range(0, 32));
        else len = LEN_W'($urandom_range(1, 32));
      end
      it = route_add_item(pfx, len, $urandom);
    end else begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        dest = sb.local_addr;
      end else if (roll < 65 && sb.occupancy() > 0) begin
        sb.pick_route(pfx, len);
        dest = pfx | ($urandom & ~sb.prefix_mask(len));
      end else begin
        dest = $urandom;
      end
      roll = $urandom_range(99);
      if (roll < 8) ttl = 8'd0;
      else if (roll < 16) ttl = 8'd1;
      else if (roll < 22) ttl = 8'd255;
      else if (roll < 28) ttl = 8'd2;
      else ttl = TTL_W'($urandom_range(255));
      it = header_item(dest, ttl, $urandom);
      it.route_prefix   = $urandom;
      it.route_mask_len = LEN_W'($urandom);
      it.route_next_hop = $urandom;
      it.header_word0   = $urandom;
      it.header_word1   = $urandom;
      it.header_word3   = $urandom;
    end
    return it;
  endfunction

  // Offer one item with random gaps and wait for it to be taken
  task push_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  // Stop sending and wait for every outstanding result
  task drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_local_addr(logic [ADDR_W-1:0] addr);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.local_addr = addr;
  endtask

  task run_random(int count, int send_pct, int recv_pct, bit may_fill);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) push_item(random_item(may_fill));
    drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.item   <= '0;
    sb = new();
    send_idle_pct = 17;
    recv_idle_pct = 74;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: local delivery and no route
    write_local_addr(32'h0000_0000);
    push_item(header_item(32'h0000_0000, 8'd0, 32'h1234_5678));
    push_item(header_item(32'h0a00_0001, 8'd64, 32'h0000_0000));
    // Masking, saturated length, overwrite of same key
    push_item(route_add_item(32'h0a00_00ff, 6'd8, 32'hc0a8_0001));
    push_item(route_add_item(32'h0a01_0000, 6'd16, 32'hc0a8_0002));
    push_item(route_add_item(32'h0a01_0203, 6'd63, 32'hc0a8_0003));
    push_item(route_add_item(32'h0a01_0203, 6'd32, 32'hc0a8_0004));
    push_item(route_add_item(32'h0aff_ffff, 6'd8, 32'hc0a8_0005));
    // Longest match, TTL wrap, TTL discard, no route
    push_item(header_item(32'h0a01_0203, 8'd64, 32'h4500_0054));
    push_item(header_item(32'h0a01_05ff, 8'd0, 32'h4500_0054));
    push_item(header_item(32'h0a7f_0000, 8'd1, 32'h4500_0054));
    push_item(header_item(32'h0b00_0000, 8'd200, 32'h4500_0054));
    push_item(header_item(32'h0a00_0000, 8'd2, 32'h0000_0000));
    push_item(header_item(32'h0aff_ffff, 8'd255, 32'hffff_ffff));
    push_item(route_add_item(32'hffff_ffff, 6'd32, 32'hffff_ffff));
    push_item(route_add_item(32'h0000_0000, 6'd1, 32'h0000_0000));
    push_item(header_item(32'hffff_ffff, 8'd255, 32'hffff_ffff));
    drain();

    // Local delivery takes priority over a matching route
    write_local_addr(32'hffff_ffff);
    push_item(header_item(32'hffff_ffff, 8'd1, 32'h0000_0000));
    push_item(header_item(32'h0000_0000, 8'd255, 32'h5a5a_a5a5));
    push_item(header_item(32'h7fff_ffff, 8'd0, 32'ha5a5_5a5a));
    drain();

    write_local_addr($urandom);
    run_random(PHASE_ITEMS, 17, 74, 1'b0);
    write_local_addr($urandom);
    run_random(PHASE_ITEMS, 74, 17, 1'b0);

    // Default route, then let the table run full
    write_local_addr($urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_item(route_add_item($urandom, 6'd0, $urandom));
    run_random(PHASE_ITEMS, 0, 0, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_verdicts.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_verdicts.size()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
